// File: design/key_debounce_long_press_defines.svh
// assertion macros for the key debounce block
// no dependencies; included by files that carry concurrent checks
`ifndef KEY_DEBOUNCE_LONG_PRESS_DEFINES_SVH
`define KEY_DEBOUNCE_LONG_PRESS_DEFINES_SVH

`ifndef NO_ASSERTIONS
// checked while out of reset
`define KDLP_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("kdlp assertion failed");
// checked at every edge, reset included
`define KDLP_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("kdlp assertion failed");
`else
`define KDLP_ASSERT(lbl, clk, rstn, prop)
`define KDLP_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// File: design/kdlp_pkg.sv
// shared types, constants and helpers for the key debounce block
// no dependencies
package kdlp_pkg;

  localparam int unsigned KEYS           = 3;
  localparam int unsigned FILTER_SAMPLES = 4;
  localparam int unsigned PH_W           = 3;
  localparam int unsigned TIME_W         = 16;
  localparam int unsigned TICK_W         = 8;
  localparam int unsigned CFG_W          = 16;
  localparam int unsigned CFG_IDX_W      = 2;
  localparam int unsigned IN_W           = ((KEYS + 7) / 8) * 8;
  localparam int unsigned STATES_W       = PH_W * KEYS;
  localparam int unsigned OUT_W          = ((STATES_W + 7) / 8) * 8;

  localparam logic [CFG_IDX_W-1:0] CFG_TICK  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SHAKE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG  = 2'd2;

  localparam logic [TICK_W-1:0] TICK_RST  = 8'd20;
  localparam logic [TIME_W-1:0] SHAKE_RST = 16'd20;
  localparam logic [TIME_W-1:0] LONG_RST  = 16'd1000;

  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  // reported phase codes
  localparam logic [PH_W-1:0] CODE_UP       = 3'd0;
  localparam logic [PH_W-1:0] CODE_SHAKE    = 3'd1;
  localparam logic [PH_W-1:0] CODE_PRESS    = 3'd2;
  localparam logic [PH_W-1:0] CODE_LONG     = 3'd3;
  localparam logic [PH_W-1:0] CODE_DROP     = 3'd4;
  localparam logic [PH_W-1:0] CODE_RISE     = 3'd5;
  localparam logic [PH_W-1:0] CODE_LONGDROP = 3'd6;
  localparam logic [PH_W-1:0] CODE_LONGRISE = 3'd7;

  typedef enum logic [7:0] {
    PH_UP       = 8'b0000_0001,
    PH_SHAKE    = 8'b0000_0010,
    PH_PRESS    = 8'b0000_0100,
    PH_LONG     = 8'b0000_1000,
    PH_DROP     = 8'b0001_0000,
    PH_RISE     = 8'b0010_0000,
    PH_LONGDROP = 8'b0100_0000,
    PH_LONGRISE = 8'b1000_0000
  } phase_e;

  typedef struct packed {
    logic [TICK_W-1:0] tick_ms;
    logic [TIME_W-1:0] shake_ms;
    logic [TIME_W-1:0] long_ms;
  } cfg_t;

  function automatic logic [PH_W-1:0] phase_code(phase_e ph);
    logic [PH_W-1:0] c;
    unique case (ph)
      PH_UP:       c = CODE_UP;
      PH_SHAKE:    c = CODE_SHAKE;
      PH_PRESS:    c = CODE_PRESS;
      PH_LONG:     c = CODE_LONG;
      PH_DROP:     c = CODE_DROP;
      PH_RISE:     c = CODE_RISE;
      PH_LONGDROP: c = CODE_LONGDROP;
      PH_LONGRISE: c = CODE_LONGRISE;
      default:     c = CODE_UP;
    endcase
    return c;
  endfunction

endpackage

// File: design/kdlp_lane.sv
// one key lane: sample history filter, phase machine and elapsed timer
// depends on kdlp_pkg
module kdlp_lane
  import kdlp_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            raw_i,
  input  cfg_t            cfg_i,
  output logic [PH_W-1:0] code_o
);

  logic [FILTER_SAMPLES-1:0] hist_q, hist_d;
  logic                      rel_q, rel_d;
  phase_e                    phase_q, phase_d;
  logic [TIME_W-1:0]         elapsed_q, elapsed_d;
  logic [TIME_W:0]           sum;
  logic [TIME_W-1:0]         elapsed_inc;
  logic                      level;

  always_comb begin
    hist_d = {hist_q[FILTER_SAMPLES-2:0], raw_i};
    if (hist_d == '0) begin
      rel_d = 1'b0;
    end else if (hist_d == {FILTER_SAMPLES{1'b1}}) begin
      rel_d = 1'b1;
    end else begin
      rel_d = rel_q;
    end
  end

  assign level = ~rel_d;
  assign sum = {1'b0, elapsed_q} + {{(TIME_W + 1 - TICK_W){1'b0}}, cfg_i.tick_ms};
  // saturate at the top of the timer range
  assign elapsed_inc = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];

  always_comb begin
    phase_d   = phase_q;
    elapsed_d = elapsed_q;
    unique case (phase_q)
      PH_UP: begin
        if (level) begin
          phase_d   = PH_SHAKE;
          elapsed_d = '0;
        end
      end
      PH_SHAKE: begin
        if (level) begin
          if (elapsed_inc > cfg_i.shake_ms) begin
            phase_d   = PH_DROP;
            elapsed_d = '0;
          end else begin
            elapsed_d = elapsed_inc;
          end
        end else begin
          phase_d   = PH_UP;
          elapsed_d = '0;
        end
      end
      PH_PRESS: begin
        if (level) begin
          if (elapsed_inc > cfg_i.long_ms) begin
            phase_d   = PH_LONGDROP;
            elapsed_d = '0;
          end else begin
            elapsed_d = elapsed_inc;
          end
        end else begin
          phase_d   = PH_RISE;
          elapsed_d = '0;
        end
      end
      PH_LONG: begin
        phase_d = level ? PH_LONG : PH_LONGRISE;
      end
      PH_DROP: begin
        if (level) begin
          phase_d   = PH_PRESS;
          elapsed_d = '0;
        end else begin
          phase_d = PH_UP;
        end
      end
      PH_LONGDROP: begin
        if (level) begin
          phase_d   = PH_LONG;
          elapsed_d = '0;
        end else begin
          phase_d = PH_UP;
        end
      end
      default: phase_d = PH_UP;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q    <= {FILTER_SAMPLES{1'b1}};
      rel_q     <= 1'b1;
      phase_q   <= PH_UP;
      elapsed_q <= '0;
    end else if (en_i) begin
      hist_q    <= hist_d;
      rel_q     <= rel_d;
      phase_q   <= phase_d;
      elapsed_q <= elapsed_d;
    end
  end

  // code of the phase this tick leaves behind
  assign code_o = phase_code(phase_d);

endmodule

// File: design/kdlp_merge.sv
// merging stage: packs the lane phase codes into one output word register
// depends on kdlp_pkg
module kdlp_merge
  import kdlp_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      load_i,
  input  logic [KEYS-1:0][PH_W-1:0] codes_i,
  input  logic                      take_i,
  output logic                      valid_o,
  output logic [OUT_W-1:0]          data_o
);

  logic [OUT_W-1:0] data_q, data_d;
  logic             valid_q, valid_d;

  always_comb begin
    data_d = '0;
    for (int k = 0; k < KEYS; k++) begin
      data_d[PH_W*k +: PH_W] = codes_i[k];
    end
  end

  assign valid_d = load_i | (valid_q & ~take_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// File: design/key_debounce_long_press.sv
// key debounce with long-press detection, one lane per key plus a packing stage
// an accepted scan tick shows its key states from the next cycle, held in the output register
// throughput: one tick per cycle unless stalled; a new tick is taken as the last word drains
// reset (async, active low): keys released, phases up, timers zero, defaults loaded
// depends on kdlp_pkg, kdlp_lane, kdlp_merge and the assertion macro header
`include "key_debounce_long_press_defines.svh"

module key_debounce_long_press
  import kdlp_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [IN_W-1:0]      s_axis_tdata,  // raw_keys
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [OUT_W-1:0]     m_axis_tdata   // key_states
);

  cfg_t                      cfg_q;
  logic                      accept;
  logic [KEYS-1:0][PH_W-1:0] codes;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tick_ms  <= TICK_RST;
      cfg_q.shake_ms <= SHAKE_RST;
      cfg_q.long_ms  <= LONG_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_TICK:  cfg_q.tick_ms  <= cfg_wdata_i[TICK_W-1:0];
        CFG_SHAKE: cfg_q.shake_ms <= cfg_wdata_i[TIME_W-1:0];
        CFG_LONG:  cfg_q.long_ms  <= cfg_wdata_i[TIME_W-1:0];
        default: ;
      endcase
    end
  end

  // output word register frees up in the same cycle it is taken
  assign s_axis_tready = ~m_axis_tvalid | m_axis_tready;
  assign accept        = s_axis_tvalid & s_axis_tready;

  for (genvar k = 0; k < KEYS; k++) begin : g_lane
    kdlp_lane u_lane (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (accept),
      .raw_i  (s_axis_tdata[k]),
      .cfg_i  (cfg_q),
      .code_o (codes[k])
    );
  end

  kdlp_merge u_merge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (accept),
    .codes_i (codes),
    .take_i  (m_axis_tready),
    .valid_o (m_axis_tvalid),
    .data_o  (m_axis_tdata)
  );

  `KDLP_ASSERT(a_accept_gives_word, clk_i, rst_ni, accept |=> m_axis_tvalid)
  `KDLP_ASSERT(a_stalled_word_kept, clk_i, rst_ni,
               (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
  // the word register is only known once reset has reached it
  `KDLP_ASSERT_ALWAYS(a_no_word_in_reset, clk_i, !rst_ni |=> !m_axis_tvalid)

endmodule

// File: test/key_debounce_long_press_tb.sv
// self-checking testbench for key_debounce_long_press: scan ticks in, packed key states out
// a scoreboard class predicts every state word; depends on kdlp_pkg and the top level only
module key_debounce_long_press_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import kdlp_pkg::*;

  localparam int unsigned CLK_HALF_NS = 6;
  localparam int unsigned RESET_CYCLES = 3;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned MAX_REPORTS = 10;
  localparam int unsigned PHASES = 8;
  localparam int unsigned SETTLE_CYCLES = 4;
  // index with no register behind it
  localparam logic [CFG_IDX_W-1:0] CFG_NONE = 2'd3;

  typedef enum int unsigned {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

  class key_state_board;
    logic [TICK_W-1:0]         tick_ms;
    logic [TIME_W-1:0]         shake_ms;
    logic [TIME_W-1:0]         long_ms;
    logic [FILTER_SAMPLES-1:0] history [KEYS];
    logic                      released [KEYS];
    logic [PH_W-1:0]           phase [KEYS];
    logic [TIME_W-1:0]         elapsed [KEYS];
    logic [STATES_W-1:0]       states_q [$];
    int unsigned               words_checked;
    int unsigned               mismatches;
    int unsigned               strays;
    int unsigned               code_seen [8];

    function new();
      tick_ms  = TICK_RST;
      shake_ms = SHAKE_RST;
      long_ms  = LONG_RST;
      for (int k = 0; k < KEYS; k++) begin
        history[k]  = '1;
        released[k] = 1'b1;
        phase[k]    = CODE_UP;
        elapsed[k]  = '0;
      end
      for (int c = 0; c < 8; c++) code_seen[c] = 0;
      words_checked = 0;
      mismatches    = 0;
      strays        = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
      case (idx)
        CFG_TICK:  tick_ms  = value[TICK_W-1:0];
        CFG_SHAKE: shake_ms = value[TIME_W-1:0];
        CFG_LONG:  long_ms  = value[TIME_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [TIME_W-1:0] timer_add(logic [TIME_W-1:0] t);
      logic [TIME_W:0] sum;
      sum = {1'b0, t} + tick_ms;
      return (sum > TIME_MAX) ? TIME_MAX : sum[TIME_W-1:0];
    endfunction

    function void note_tick(logic [KEYS-1:0] raw);
      logic [STATES_W-1:0] states;
      logic                pressed;
      states = '0;
      for (int k = 0; k < KEYS; k++) begin
        history[k] = {history[k][FILTER_SAMPLES-2:0], raw[k]};
        // filtered level moves only once the whole history agrees
        if (history[k] == '0) released[k] = 1'b0;
        else if (history[k] == '1) released[k] = 1'b1;
        pressed = ~released[k];
        case (phase[k])
          CODE_UP: begin
            if (pressed) begin
              phase[k]   = CODE_SHAKE;
              elapsed[k] = '0;
            end
          end
          CODE_SHAKE: begin
            if (pressed) begin
              elapsed[k] = timer_add(elapsed[k]);
              if (elapsed[k] > shake_ms) begin
                phase[k]   = CODE_DROP;
                elapsed[k] = '0;
              end
            end else begin
              phase[k]   = CODE_UP;
              elapsed[k] = '0;
            end
          end
          CODE_PRESS: begin
            if (pressed) begin
              elapsed[k] = timer_add(elapsed[k]);
              if (elapsed[k] > long_ms) begin
                phase[k]   = CODE_LONGDROP;
                elapsed[k] = '0;
              end
            end else begin
              phase[k]   = CODE_RISE;
              elapsed[k] = '0;
            end
          end
          CODE_LONG: begin
            if (!pressed) phase[k] = CODE_LONGRISE;
          end
          CODE_DROP: begin
            if (pressed) begin
              phase[k]   = CODE_PRESS;
              elapsed[k] = '0;
            end else begin
              phase[k] = CODE_UP;
            end
          end
          CODE_LONGDROP: begin
            if (pressed) begin
              phase[k]   = CODE_LONG;
              elapsed[k] = '0;
            end else begin
              phase[k] = CODE_UP;
            end
          end
          default: phase[k] = CODE_UP;
        endcase
        states[PH_W*k +: PH_W] = phase[k];
        code_seen[phase[k]]++;
      end
      states_q.push_back(states);
    endfunction

    function void check_states(logic [OUT_W-1:0] word);
      logic [STATES_W-1:0] want;
      if (states_q.size() == 0) begin
        strays++;
        if (mismatches + strays <= MAX_REPORTS)
          $display("unexpected state word %h with nothing outstanding", word);
        return;
      end
      want = states_q.pop_front();
      words_checked++;
      if (word[STATES_W-1:0] !== want) begin
        mismatches++;
        if (mismatches + strays <= MAX_REPORTS)
          $display("key_states mismatch at word %0d: expected %h, got %h",
                   words_checked, want, word[STATES_W-1:0]);
      end
    endfunction

    function int unsigned pending();
      return states_q.size();
    endfunction

    function int unsigned failures();
      return mismatches + strays + states_q.size();
    endfunction
  endclass

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i     = '0;
  logic [CFG_W-1:0]     cfg_wdata_i   = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [IN_W-1:0]      s_axis_tdata  = '0;  // raw_keys
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OUT_W-1:0]     m_axis_tdata;        // key_states

  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  int unsigned ticks_sent    = 0;

  key_state_board board = new();

  // all pressed, a mixed history while held, release, then every key pattern
  logic [KEYS-1:0] dir_ticks [24] = '{
    3'b000, 3'b000, 3'b000, 3'b000, 3'b000, 3'b000, 3'b000, 3'b000,
    3'b101, 3'b010, 3'b101,
    3'b111, 3'b111, 3'b111, 3'b111, 3'b111,
    3'b000, 3'b001, 3'b010, 3'b011, 3'b100, 3'b101, 3'b110, 3'b111
  };

  key_debounce_long_press u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #(CLK_HALF_NS) clk_i = ~clk_i;

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= stall_pct);
  end

  // input word noted before the output check: a same-edge result is an older one
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) board.note_tick(s_axis_tdata[KEYS-1:0]);
      if (m_axis_tvalid && m_axis_tready) board.check_states(m_axis_tdata);
    end
  end

  task automatic set_idle(idle_mode_e mode);
    case (mode)
      IDLE_NONE: begin send_idle_pct = 0;  stall_pct = 0;  end
      IDLE_SEND: begin send_idle_pct = 45; stall_pct = 0;  end
      IDLE_RECV: begin send_idle_pct = 0;  stall_pct = 45; end
      default:   begin send_idle_pct = 13; stall_pct = 13; end
    endcase
  endtask

  task automatic send_tick(input logic [KEYS-1:0] raw);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(IN_W-KEYS){1'b0}}, raw};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    ticks_sent++;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (board.pending() > 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    board.write_reg(idx, value);
  endtask

  task automatic close_writes();
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // each key holds a level for a short or a long run, with single-tick glitches on top
  task automatic run_presses(input int unsigned count, input int unsigned max_run);
    logic [KEYS-1:0] level;
    logic [KEYS-1:0] raw;
    int unsigned     run_left [KEYS];
    level = KEYS'($urandom_range(7));
    for (int k = 0; k < KEYS; k++) run_left[k] = 0;
    repeat (count) begin
      for (int k = 0; k < KEYS; k++) begin
        if (run_left[k] == 0) begin
          level[k]    = ~level[k];
          run_left[k] = ($urandom_range(1) == 0) ? $urandom_range(6, 1)
                                                 : $urandom_range(max_run, max_run / 2);
        end
        run_left[k]--;
        raw[k] = level[k] ^ ($urandom_range(99) < 6);
      end
      if ($urandom_range(99) < 3) raw = KEYS'($urandom_range(7));
      send_tick(raw);
    end
  endtask

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("no completion within %0d cycles", CYCLE_LIMIT);
    $display("[key_debounce_long_press] ERROR");
    $finish;
  end

  initial begin
    logic [TICK_W-1:0] tick;
    logic [TIME_W-1:0] shake;
    logic [TIME_W-1:0] lng;
    int unsigned       count;
    int unsigned       max_run;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part on the reset settings; wide tick keeps its low byte, stray index dropped
    set_idle(IDLE_NONE);
    write_reg(CFG_TICK, {8'hA5, TICK_RST});
    write_reg(CFG_NONE, 16'h0001);
    close_writes();
    foreach (dir_ticks[i]) send_tick(dir_ticks[i]);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      count = 200;
      case (p)
        0: begin tick = TICK_RST; shake = SHAKE_RST; lng = LONG_RST; max_run = 80; end
        // timer runs into saturation and never passes the long limit
        1: begin tick = 8'd255; shake = 16'd0; lng = 16'hFFFF; max_run = 320; count = 300; end
        // stuck in shake, time never advances
        2: begin tick = 8'd0; shake = 16'd0; lng = 16'd0; max_run = 30; end
        3: begin tick = 8'd1; shake = 16'd0; lng = 16'd0; max_run = 12; end
        4: begin tick = 8'd1; shake = 16'hFFFF; lng = 16'd1; max_run = 40; end
        6: begin tick = 8'd255; shake = 16'hFFFF; lng = 16'hFFFF; max_run = 300; count = 300; end
        default: begin
          tick    = TICK_W'($urandom_range(16, 1));
          shake   = TIME_W'($urandom_range(60));
          lng     = TIME_W'($urandom_range(300));
          max_run = 60;
        end
      endcase
      write_reg(CFG_TICK, {8'($urandom_range(255)), tick});
      write_reg(CFG_SHAKE, shake);
      write_reg(CFG_LONG, lng);
      close_writes();
      set_idle(idle_mode_e'(p % 4));
      run_presses(count, max_run);
      drain();
    end

    $display("%0d scan ticks over %0d register settings, %0d state words; up %0d shake %0d",
             ticks_sent, PHASES + 1, board.words_checked,
             board.code_seen[CODE_UP], board.code_seen[CODE_SHAKE]);
    $display("  press %0d long %0d drop %0d rise %0d longdrop %0d longrise %0d; bad %0d",
             board.code_seen[CODE_PRESS], board.code_seen[CODE_LONG],
             board.code_seen[CODE_DROP], board.code_seen[CODE_RISE],
             board.code_seen[CODE_LONGDROP], board.code_seen[CODE_LONGRISE],
             board.failures());
    if (board.failures() == 0) begin
      $display("[key_debounce_long_press] OK");
    end else begin
      $display("[key_debounce_long_press] ERROR");
    end
    $finish;
  end

endmodule
